// File: hdl/jdl_pkg.sv
// shared constants for the jittered dda line plotter
// widths, register indexes, command and mode codes and divider sizes; no dependencies
package jdl_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_BITS   = 32;
	localparam int RAND_BITS  = 15;
	localparam int SPREAD_BITS = 4;
	localparam int COLOR_BITS = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = COORD_BITS;

	// step count holds span + 1, one bit wider than a coordinate
	localparam int COUNT_BITS = COORD_BITS + 1;
	// dividend is the absolute span scaled to fixed point
	localparam int DIV_BITS   = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
	// jittered position: integer part plus two guard bits
	localparam int POS_BITS   = ACC_BITS - FRAC_BITS + 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BOTTOM  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPREAD_SHIFT = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_PLOT_MODE    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_COLOR = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COLOR   = 3'd7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic MODE_SINGLE = 1'b0;
	localparam logic MODE_PLUS   = 1'b1;

endpackage

// File: hdl/jdl_if.sv
// valid/ready channel interfaces for the plotter command and pixel streams
// depends on jdl_pkg
interface jdl_cmd_if;
	logic valid;
	logic ready;
	logic command;
	logic signed [jdl_pkg::COORD_BITS-1:0] start_x;
	logic signed [jdl_pkg::COORD_BITS-1:0] start_y;
	logic signed [jdl_pkg::COORD_BITS-1:0] end_x;
	logic signed [jdl_pkg::COORD_BITS-1:0] end_y;
	logic [jdl_pkg::RAND_BITS-1:0] rand_x;
	logic [jdl_pkg::RAND_BITS-1:0] rand_y;

	modport source (output valid, command, start_x, start_y, end_x, end_y, rand_x, rand_y,
		input ready);
	modport sink (input valid, command, start_x, start_y, end_x, end_y, rand_x, rand_y,
		output ready);
endinterface

interface jdl_pix_if;
	logic valid;
	logic ready;
	logic [jdl_pkg::COORD_BITS-1:0] pix_x;
	logic [jdl_pkg::COORD_BITS-1:0] pix_y;
	logic [jdl_pkg::COLOR_BITS-1:0] pix_color;
	logic write_enable;
	logic line_finished;
	logic last;

	modport source (output valid, pix_x, pix_y, pix_color, write_enable, line_finished, last,
		input ready);
	modport sink (input valid, pix_x, pix_y, pix_color, write_enable, line_finished, last,
		output ready);
endinterface

// File: hdl/jittered_dda_line_plotter_top.sv
// jittered dda line plotter, top level and only module
// depends on jdl_pkg and the channel interfaces in jdl_if.sv
// load: accept, the divider works through the x axis and then the y axis, then the
//   result is loaded into the output register
// step: accept, a position/clip state, then one result per cycle (one or five)
//   into the output register unless the sink stalls it; next transaction accepted after the last result
// the shared restoring divider (one subtract per cycle) sets the load time
// arst_n clears the sequencer, the line state and the config to their defaults
module jittered_dda_line_plotter_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [jdl_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [jdl_pkg::CFG_DATA_BITS-1:0] cfg_data,
	jdl_cmd_if.sink   cmd_in,
	jdl_pix_if.source pix_out
);
	import jdl_pkg::*;

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_STEP = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;

	// configuration registers
	logic [COORD_BITS-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic [SPREAD_BITS-1:0] spread_q;
	logic mode_q;
	logic [COLOR_BITS-1:0] center_color_q, edge_color_q;

	// line state
	logic [ACC_BITS-1:0] x_acc_q, y_acc_q, x_inc_q, y_inc_q;
	logic [COUNT_BITS-1:0] steps_q;

	// divider state
	logic [COUNT_BITS-1:0] div_t_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [DIV_BITS-1:0] dvd_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic div_axis_q;
	logic neg_q, neg_y_q;
	logic [COORD_BITS-1:0] abs_dy_q;

	// step operands and emit state
	logic [RAND_BITS-1:0] rand_x_q, rand_y_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic we_q, fin_q, plus_q;
	logic [2:0] emit_idx_q;

	// output register
	logic out_valid_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [COLOR_BITS-1:0] out_color_q;
	logic out_we_q, out_fin_q, out_last_q;

	logic cmd_fire;
	assign cmd_in.ready = (state_q == S_IDLE);
	assign cmd_fire = cmd_in.valid && (state_q == S_IDLE);

	assign pix_out.valid         = out_valid_q;
	assign pix_out.pix_x         = out_x_q;
	assign pix_out.pix_y         = out_y_q;
	assign pix_out.pix_color     = out_color_q;
	assign pix_out.write_enable  = out_we_q;
	assign pix_out.line_finished = out_fin_q;
	assign pix_out.last          = out_last_q;

	// load setup: spans, their magnitudes and the step count
	logic signed [COORD_BITS:0] ddx, ddy;
	logic [COORD_BITS-1:0] abs_dx, abs_dy;
	logic [COUNT_BITS-1:0] span_t;

	always_comb begin
		ddx = {cmd_in.end_x[COORD_BITS-1], cmd_in.end_x}
			- {cmd_in.start_x[COORD_BITS-1], cmd_in.start_x};
		ddy = {cmd_in.end_y[COORD_BITS-1], cmd_in.end_y}
			- {cmd_in.start_y[COORD_BITS-1], cmd_in.start_y};
		abs_dx = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : ddx[COORD_BITS-1:0];
		abs_dy = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : ddy[COORD_BITS-1:0];
		span_t = (abs_dx > abs_dy) ? ({1'b0, abs_dx} + 1'b1) : ({1'b0, abs_dy} + 1'b1);
	end

	// shared divider datapath: one restoring step per cycle
	logic [COUNT_BITS:0] trial, diff;
	logic qbit;
	logic [DIV_BITS-1:0] quo_next;
	logic [ACC_BITS-1:0] quo_signed;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_BITS-1]};
		diff = trial - {1'b0, div_t_q};
		qbit = (trial >= {1'b0, div_t_q});
		quo_next = {dvd_q[DIV_BITS-2:0], qbit};
		quo_signed = neg_q ? (-ACC_BITS'(quo_next)) : ACC_BITS'(quo_next);
	end

	// jittered position and clip test
	logic [SPREAD_BITS-1:0] shamt;
	logic signed [POS_BITS-1:0] half, pos_x, pos_y;
	logic signed [POS_BITS-1:0] cl, ct, cr, cb;
	logic pass;

	always_comb begin
		shamt = SPREAD_BITS'(RAND_BITS) - spread_q;
		half = POS_BITS'(1) << spread_q;
		pos_x = POS_BITS'($signed(x_acc_q[ACC_BITS-1:FRAC_BITS]))
			+ $signed(POS_BITS'(rand_x_q >> shamt)) - half;
		pos_y = POS_BITS'($signed(y_acc_q[ACC_BITS-1:FRAC_BITS]))
			+ $signed(POS_BITS'(rand_y_q >> shamt)) - half;
		cl = $signed(POS_BITS'(clip_left_q));
		ct = $signed(POS_BITS'(clip_top_q));
		cr = $signed(POS_BITS'(clip_right_q));
		cb = $signed(POS_BITS'(clip_bottom_q));
		if (mode_q == MODE_PLUS) begin
			pass = (pos_x > cl) && (pos_y > ct) && (pos_x < cr) && (pos_y < cb);
		end else begin
			pass = (pos_x >= cl) && (pos_y >= ct) && (pos_x <= cr) && (pos_y <= cb);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q    <= '0;
			clip_top_q     <= '0;
			clip_right_q   <= COORD_BITS'(319);
			clip_bottom_q  <= COORD_BITS'(199);
			spread_q       <= '0;
			mode_q         <= MODE_SINGLE;
			center_color_q <= '0;
			edge_color_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:    clip_left_q    <= cfg_data;
				REG_CLIP_TOP:     clip_top_q     <= cfg_data;
				REG_CLIP_RIGHT:   clip_right_q   <= cfg_data;
				REG_CLIP_BOTTOM:  clip_bottom_q  <= cfg_data;
				REG_SPREAD_SHIFT: spread_q       <= cfg_data[SPREAD_BITS-1:0];
				REG_PLOT_MODE:    mode_q         <= cfg_data[0];
				REG_CENTER_COLOR: center_color_q <= cfg_data[COLOR_BITS-1:0];
				REG_EDGE_COLOR:   edge_color_q   <= cfg_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// emit selection for the current result of a step or load
	logic out_load;
	logic [COORD_BITS-1:0] sel_x, sel_y;
	logic [COLOR_BITS-1:0] sel_color;
	logic sel_last;

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || pix_out.ready);

	always_comb begin
		sel_x = px_q;
		sel_y = py_q;
		sel_color = we_q ? edge_color_q : '0;
		sel_last = 1'b0;
		unique case (emit_idx_q)
			3'd0: begin
				sel_color = we_q ? center_color_q : '0;
				sel_last = !plus_q;
			end
			3'd1: sel_y = py_q + 1'b1;
			3'd2: sel_y = py_q - 1'b1;
			3'd3: sel_x = px_q - 1'b1;
			3'd4: begin
				sel_x = px_q + 1'b1;
				sel_last = 1'b1;
			end
			default: sel_last = 1'b1;
		endcase
	end

	// output register, holds a result until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q     <= sel_x;
			out_y_q     <= sel_y;
			out_color_q <= sel_color;
			out_we_q    <= we_q;
			out_fin_q   <= fin_q;
			out_last_q  <= sel_last;
		end
	end

	// sequencer and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_acc_q <= '0;
			y_acc_q <= '0;
			x_inc_q <= '0;
			y_inc_q <= '0;
			steps_q <= '0;
			emit_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						if (cmd_in.command == CMD_LOAD) begin
							// accumulators start at the scaled start point
							x_acc_q <= ACC_BITS'($signed(cmd_in.start_x)) << FRAC_BITS;
							y_acc_q <= ACC_BITS'($signed(cmd_in.start_y)) << FRAC_BITS;
							steps_q <= span_t;
							state_q <= S_DIV;
						end else if (steps_q == '0) begin
							// exhausted line: one empty result, nothing changes
							emit_idx_q <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_STEP;
						end
					end
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						if (!div_axis_q) begin
							x_inc_q <= quo_signed;
						end else begin
							y_inc_q <= quo_signed;
							emit_idx_q <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_STEP: begin
					steps_q <= steps_q - 1'b1;
					x_acc_q <= x_acc_q + x_inc_q;
					y_acc_q <= y_acc_q + y_inc_q;
					emit_idx_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load) begin
						if (sel_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// divider and emit payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					rand_x_q <= cmd_in.rand_x;
					rand_y_q <= cmd_in.rand_y;
					// load result and exhausted step both carry zero pixel fields
					px_q   <= '0;
					py_q   <= '0;
					we_q   <= 1'b0;
					plus_q <= 1'b0;
					fin_q  <= (cmd_in.command == CMD_STEP);
					div_t_q <= span_t;
					rem_q <= '0;
					dvd_q <= {abs_dx, FRAC_BITS'(0)};
					div_cnt_q <= DIV_CNT_BITS'(DIV_BITS - 1);
					div_axis_q <= 1'b0;
					neg_q <= ddx[COORD_BITS];
					neg_y_q <= ddy[COORD_BITS];
					abs_dy_q <= abs_dy;
				end
			end
			S_DIV: begin
				if (div_cnt_q == '0) begin
					// second axis reuses the same subtractor
					rem_q <= '0;
					dvd_q <= {abs_dy_q, FRAC_BITS'(0)};
					div_cnt_q <= DIV_CNT_BITS'(DIV_BITS - 1);
					div_axis_q <= 1'b1;
					neg_q <= neg_y_q;
				end else begin
					rem_q <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
					dvd_q <= quo_next;
					div_cnt_q <= div_cnt_q - 1'b1;
				end
			end
			S_STEP: begin
				fin_q  <= (steps_q == COUNT_BITS'(1));
				we_q   <= pass;
				plus_q <= pass && (mode_q == MODE_PLUS);
				px_q   <= pass ? pos_x[COORD_BITS-1:0] : '0;
				py_q   <= pass ? pos_y[COORD_BITS-1:0] : '0;
			end
			S_EMIT: ;
			default: ;
		endcase
	end

endmodule
